// ===== design/lphb_pkg.sv =====
`default_nettype none

package lphb_pkg;

  // Quotient of the period division: at most 96, so 7 bits
  localparam int QUO_BITS = 7;
  localparam int PERIOD_W = 7;
  localparam int OFFSET_W = 5;

  // Period hyperbola constants
  localparam int NUM_BASE    = 672;
  localparam int DEN_BASE    = 7;
  localparam int LOAD_SCALE  = 5;
  localparam int PERIOD_BIAS = 30;

  // Ticks the LED stays on after each beat
  localparam int BEAT_LEN = 7;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [OFFSET_W-1:0] offset_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DIVIDE = 2'b10
  } state_t;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/lphb_div.sv =====
`default_nettype none

// Restoring divider: (672 << FRAC_BITS) / den, one quotient bit per cycle.
module lphb_div #(
  parameter int FRAC_BITS = 11
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire lphb_pkg::div_req_t                      req,
  input  wire logic [((FRAC_BITS + 4 > 24) ? FRAC_BITS + 4 : 24)-1:0] den,
  output lphb_pkg::div_rsp_t                           rsp,
  output lphb_pkg::period_t                            quo
);

  localparam int DenW  = (FRAC_BITS + 4 > 24) ? FRAC_BITS + 4 : 24;
  localparam int CmpW  = DenW + lphb_pkg::QUO_BITS - 1;
  localparam int StepW = $clog2(lphb_pkg::QUO_BITS);
  localparam logic [CmpW-1:0] NUM = CmpW'(lphb_pkg::NUM_BASE) << FRAC_BITS;
  localparam logic [StepW-1:0] LAST_STEP = StepW'(lphb_pkg::QUO_BITS - 1);

  logic [CmpW-1:0]  rem;
  logic [CmpW-1:0]  dsh;
  logic [StepW-1:0] step;
  logic             busy;
  logic             done;
  logic [CmpW:0]    diff;
  logic             fits;

  // Trial subtract of the shifted divisor
  assign diff = {1'b0, rem} - {1'b0, dsh};
  assign fits = ~diff[CmpW];

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, divisor and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= NUM;
      dsh <= CmpW'(den) << (lphb_pkg::QUO_BITS - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= diff[CmpW-1:0];
      end
      dsh <= dsh >> 1;
      quo <= {quo[lphb_pkg::QUO_BITS-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

`default_nettype wire

// ===== design/load_paced_heartbeat_led_unit.sv =====
// Heartbeat LED paced by load. Each tick transaction carries the load average
// (FRAC_BITS fraction bits) and yields an led_level transaction only when the
// LED is switched: on at count 0 and at the second-beat offset, off seven
// ticks after each. A tick inside the beat period does not hold off the next
// tick. A tick that ends the period starts the period division, a restoring
// divider that makes one quotient bit per cycle; after that tick is accepted,
// tick_ready stays low until the divider is done and the new period is
// loaded. No new tick is taken while an led_level result waits unless
// led_ready takes it in the same cycle.
`default_nettype none

module load_paced_heartbeat_led_unit #(
  parameter int FRAC_BITS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick_valid,
  output logic             tick_ready,
  input  wire logic [19:0] load_average,
  output logic             led_valid,
  input  wire logic        led_ready,
  output logic             led_level
);

  localparam int DenW = (FRAC_BITS + 4 > 24) ? FRAC_BITS + 4 : 24;

  lphb_pkg::state_t  state;
  lphb_pkg::period_t tick_count;
  lphb_pkg::period_t beat_period;
  lphb_pkg::offset_t second_beat_offset;
  lphb_pkg::period_t count_inc;
  lphb_pkg::period_t quo;
  lphb_pkg::period_t period_next;
  lphb_pkg::div_req_t div_req;
  lphb_pkg::div_rsp_t div_rsp;
  logic [DenW-1:0]   den;
  logic              accept;
  logic              beat_on;
  logic              beat_off;
  logic              wrap;

  assign tick_ready = (state == lphb_pkg::ST_IDLE) && (!led_valid || led_ready);
  assign accept     = tick_valid && tick_ready;

  // LED switch points
  assign beat_on  = (tick_count == '0) ||
                    (tick_count == lphb_pkg::PERIOD_W'(second_beat_offset));
  assign beat_off = (tick_count == lphb_pkg::PERIOD_W'(lphb_pkg::BEAT_LEN)) ||
                    (tick_count == lphb_pkg::PERIOD_W'(second_beat_offset) +
                                   lphb_pkg::PERIOD_W'(lphb_pkg::BEAT_LEN));

  // Counter advance and end of period
  assign count_inc = tick_count + 1'b1;
  assign wrap      = count_inc > beat_period;

  // Divisor: 5*load + (7 << FRAC_BITS)
  assign den = (DenW'(load_average) << 2) + DenW'(load_average) +
               (DenW'(lphb_pkg::DEN_BASE) << FRAC_BITS);

  assign div_req.start = accept && wrap;
  assign period_next   = quo + lphb_pkg::PERIOD_W'(lphb_pkg::PERIOD_BIAS);

  lphb_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .den (den),
    .rsp (div_rsp),
    .quo (quo)
  );

  // Sequencer and beat state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= lphb_pkg::ST_IDLE;
      tick_count         <= '0;
      beat_period        <= '0;
      second_beat_offset <= '0;
      led_valid          <= 1'b0;
    end else begin
      if (accept) begin
        led_valid <= beat_on || beat_off;
      end else if (led_ready) begin
        led_valid <= 1'b0;
      end
      unique case (state)
        lphb_pkg::ST_IDLE: begin
          if (accept) begin
            tick_count <= wrap ? '0 : count_inc;
            if (wrap) begin
              state <= lphb_pkg::ST_DIVIDE;
            end
          end
        end
        lphb_pkg::ST_DIVIDE: begin
          if (div_rsp.done) begin
            beat_period        <= period_next;
            second_beat_offset <= period_next[lphb_pkg::PERIOD_W-1:2];
            state              <= lphb_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lphb_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      led_level <= beat_on;
    end
  end

  // Counter never runs past the period
  assert property (@(posedge clk) disable iff (rst) tick_count <= beat_period)
    else $error("tick_count beyond beat_period");

  // Offset always tracks a quarter of the period
  assert property (@(posedge clk) disable iff (rst)
    second_beat_offset == beat_period[lphb_pkg::PERIOD_W-1:2])
    else $error("second_beat_offset out of step with beat_period");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == lphb_pkg::ST_DIVIDE))
    else $error("divider done outside divide state");

  // A period-ending tick hands off to the divider
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == lphb_pkg::ST_DIVIDE) && div_rsp.busy)
    else $error("divider not started on period end");

  // Computed period stays at or above the hyperbola's minimum, PERIOD_BIAS
  assert property (@(posedge clk) disable iff (rst)
    (state == lphb_pkg::ST_DIVIDE) && div_rsp.done |=>
      (beat_period >= lphb_pkg::PERIOD_W'(lphb_pkg::PERIOD_BIAS)))
    else $error("beat_period below minimum");

endmodule

`default_nettype wire
